// File: hdl/mds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mds_pkg: shared types and constants of the 2x2 RGBA mip reducer
// Sizes, register indexes and the block descriptor passed to the back end.
// ----------------------------------------------------------------------------
package mds_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;
  localparam int LineDepth = MaxWidth / 2;
  localparam int LineAw    = $clog2(LineDepth);
  localparam int SizeW     = 13;
  localparam int CntW      = $clog2(MaxHeight + 1);
  localparam int QueueDepth = 4;
  localparam int QueueAw   = $clog2(QueueDepth);

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegMode   = 2'd2;

  // four 10-bit channel sums of one block, plus flags
  typedef struct packed {
    logic [9:0] sum_r;
    logic [9:0] sum_g;
    logic [9:0] sum_b;
    logic [9:0] sum_a;
    logic       normal;
    logic       last;
  } blk_t;

endpackage

// File: hdl/mds_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mds_front: pixel intake and 2x2 block summing
// Tracks column and row, forms horizontal pair sums, keeps the upper row of
// pair sums in a line memory and pushes each completed block sum.
// ----------------------------------------------------------------------------
module mds_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [12:0]             cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              red_i,
  input  logic [7:0]              green_i,
  input  logic [7:0]              blue_i,
  input  logic [7:0]              alpha_i,
  input  logic                    blk_full_i,
  output logic                    blk_push_o,
  output mds_pkg::blk_t           blk_o
);

  localparam int CW = mds_pkg::CntW;

  logic [CW-1:0] width_q, height_q, width_d, height_d;
  logic          normal_q;
  logic [CW-1:0] col_q, row_q, col_d, row_d;
  logic [31:0]   left_q;
  logic [35:0]   line_mem [mds_pkg::LineDepth];
  logic [35:0]   line_rd_q;

  // stage 2 registers
  logic          s2_q;
  logic          s2_emit_q;
  logic [8:0]    s2_pr_q, s2_pg_q, s2_pb_q, s2_pa_q;
  logic          s2_h1_q, s2_last_q;

  function automatic logic [CW-1:0] eff_size(input logic [12:0] v, input int maxv);
    logic [CW-1:0] r;
    if (v == 13'd0) r = CW'(1);
    else if (32'(v) > maxv) r = CW'(maxv);
    else r = CW'(v);
    return r;
  endfunction

  logic          accept;
  logic          w1, h1, have_pair, row_odd, wr_line, rd_line, emit;
  logic [8:0]    pr, pg, pb, pa;
  logic [CW-1:0] x, ow, oh;
  logic          last;

  // stall while a block in stage 2 waits on a full queue
  assign in_ready_o = !(s2_q && s2_emit_q && blk_full_i);
  assign accept     = in_valid_i && in_ready_o;

  assign w1 = (width_q == CW'(1));
  assign h1 = (height_q == CW'(1));
  assign row_odd = row_q[0];
  assign have_pair = w1 || col_q[0];
  assign x  = w1 ? '0 : (col_q >> 1);
  assign ow = (width_q >> 1) == '0 ? CW'(1) : (width_q >> 1);
  assign oh = (height_q >> 1) == '0 ? CW'(1) : (height_q >> 1);
  assign last = (x == ow - CW'(1)) && ((row_q >> 1) == oh - CW'(1));

  always_comb begin
    if (w1) begin
      pr = {red_i, 1'b0};
      pg = {green_i, 1'b0};
      pb = {blue_i, 1'b0};
      pa = {alpha_i, 1'b0};
    end else begin
      pr = 9'(left_q[7:0]) + 9'(red_i);
      pg = 9'(left_q[15:8]) + 9'(green_i);
      pb = 9'(left_q[23:16]) + 9'(blue_i);
      pa = 9'(left_q[31:24]) + 9'(alpha_i);
    end
  end

  assign wr_line = accept && have_pair && !h1 && !row_odd;
  assign rd_line = accept && have_pair && !h1 && row_odd;
  assign emit    = have_pair && (h1 || row_odd);

  always_comb begin
    col_d = col_q + CW'(1);
    row_d = row_q;
    if (col_d >= width_q) begin
      col_d = '0;
      row_d = row_q + CW'(1);
      if (row_d >= height_q) row_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_line) line_mem[x[mds_pkg::LineAw-1:0]] <= {pa, pb, pg, pr};
    if (rd_line) line_rd_q <= line_mem[x[mds_pkg::LineAw-1:0]];
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i && cfg_index_i == mds_pkg::RegWidth)
      width_d = eff_size(cfg_data_i, mds_pkg::MaxWidth);
    if (cfg_we_i && cfg_index_i == mds_pkg::RegHeight)
      height_d = eff_size(cfg_data_i, mds_pkg::MaxHeight);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CW'(1);
      height_q <= CW'(1);
      normal_q <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
      left_q   <= '0;
      s2_q     <= 1'b0;
      s2_emit_q <= 1'b0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      if (cfg_we_i && cfg_index_i == mds_pkg::RegMode) normal_q <= cfg_data_i[0];
      if (cfg_we_i && (cfg_index_i == mds_pkg::RegWidth || cfg_index_i == mds_pkg::RegHeight
                       || cfg_index_i == mds_pkg::RegMode)) begin
        col_q  <= '0;
        row_q  <= '0;
        left_q <= '0;
      end else if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        if (!w1 && !col_q[0]) left_q <= {alpha_i, blue_i, green_i, red_i};
      end
      if (in_ready_o) begin
        s2_q      <= accept;
        s2_emit_q <= accept && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_pr_q <= pr;
      s2_pg_q <= pg;
      s2_pb_q <= pb;
      s2_pa_q <= pa;
      s2_h1_q <= h1;
      s2_last_q <= last;
    end
  end

  assign blk_push_o = s2_q && s2_emit_q && !blk_full_i;

  always_comb begin
    blk_o.normal = normal_q;
    blk_o.last   = s2_last_q;
    if (s2_h1_q) begin
      blk_o.sum_r = {s2_pr_q, 1'b0};
      blk_o.sum_g = {s2_pg_q, 1'b0};
      blk_o.sum_b = {s2_pb_q, 1'b0};
      blk_o.sum_a = {s2_pa_q, 1'b0};
    end else begin
      blk_o.sum_r = 10'(s2_pr_q) + 10'(line_rd_q[8:0]);
      blk_o.sum_g = 10'(s2_pg_q) + 10'(line_rd_q[17:9]);
      blk_o.sum_b = 10'(s2_pb_q) + 10'(line_rd_q[26:18]);
      blk_o.sum_a = 10'(s2_pa_q) + 10'(line_rd_q[35:27]);
    end
  end

endmodule

// File: hdl/mds_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mds_queue: short block descriptor FIFO
// Decouples block summing from the pixel finishing sequencer.
// ----------------------------------------------------------------------------
module mds_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mds_pkg::blk_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mds_pkg::blk_t data_o
);

  localparam int AW = mds_pkg::QueueAw;

  mds_pkg::blk_t mem_q [mds_pkg::QueueDepth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(mds_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + AW'(1);
      if (pop_i) rp_q <= rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

endmodule

// File: hdl/mds_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mds_back: block finishing sequencer
// Box averages directly; for nonzero normals runs a bit-serial square root, a
// restoring reciprocal divide and one multiplier shared by the RGB channels.
// ----------------------------------------------------------------------------
module mds_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  mds_pkg::blk_t blk_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    red_o,
  output logic [7:0]    green_o,
  output logic [7:0]    blue_o,
  output logic [7:0]    alpha_o,
  output logic          last_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSqrt = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StEnc  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]  st_q;
  logic [5:0]  it_q;
  logic signed [10:0] n_q [3];
  logic [39:0] rad_q;        // d << 20, shifted out two bits a step
  logic [41:0] rem_q;
  logic [20:0] root_q;
  logic [31:0] dnum_q;       // divide remainder
  logic [31:0] quo_q;
  logic [1:0]  ch_q;
  logic signed [43:0] prod_q;
  logic [7:0]  o_q [4];
  logic        last_q;

  // combinational helpers
  logic [42:0] trial;
  logic [32:0] dtry;
  logic [31:0] dshift;
  logic signed [43:0] t255;
  logic signed [44:0] tr;
  logic [7:0]  enc;
  logic signed [10:0] nr, ng, nb;
  logic [21:0] sq_r, sq_g, sq_b;

  assign nr = 11'(blk_i.sum_r) - 11'sd510;
  assign ng = 11'(blk_i.sum_g) - 11'sd510;
  assign nb = 11'(blk_i.sum_b) - 11'sd510;
  assign sq_r = 22'(nr * nr);
  assign sq_g = 22'(ng * ng);
  assign sq_b = 22'(nb * nb);

  // sqrt step: bring in next two radicand bits
  assign trial = {rem_q[40:0], rad_q[39:38]} - {20'd0, root_q, 2'b01};
  // divide step on 2^30 + q/2 by q
  assign dshift = {dnum_q[30:0], quo_q[31]};
  assign dtry   = {1'b0, dshift} - {12'd0, root_q};

  assign t255 = (prod_q <<< 8) - prod_q;
  assign tr   = 45'(t255) + 45'sd1048576;

  always_comb begin
    if (t255 < 0) enc = 8'd0;
    else if ((tr >>> 21) > 45'sd255) enc = 8'd255;
    else enc = tr[28:21];
  end

  assign pop_o       = (st_q == StIdle) && !empty_i;
  assign out_valid_o = (st_q == StOut);
  assign red_o   = o_q[0];
  assign green_o = o_q[1];
  assign blue_o  = o_q[2];
  assign alpha_o = o_q[3];
  assign last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      unique case (st_q)
        StIdle: if (!empty_i) begin
          if (blk_i.normal && (sq_r + sq_g + sq_b) != '0) st_q <= StSqrt;
          else st_q <= StOut;
        end
        StSqrt: if (it_q == 6'd19) st_q <= StDiv;
        StDiv:  if (it_q == 6'd31) st_q <= StMul;
        StMul:  st_q <= StEnc;
        StEnc:  st_q <= (ch_q == 2'd2) ? StOut : StMul;
        StOut:  if (out_ready_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        it_q  <= '0;
        ch_q  <= '0;
        n_q[0] <= nr;
        n_q[1] <= ng;
        n_q[2] <= nb;
        rad_q <= {20'(sq_r + sq_g + sq_b), 20'd0};
        rem_q <= '0;
        root_q <= '0;
        last_q <= blk_i.last;
        o_q[3] <= 8'((blk_i.sum_a + 10'd2) >> 2);
        if (blk_i.normal) begin
          o_q[0] <= 8'd128;
          o_q[1] <= 8'd128;
          o_q[2] <= 8'd255;
        end else begin
          o_q[0] <= 8'((blk_i.sum_r + 10'd2) >> 2);
          o_q[1] <= 8'((blk_i.sum_g + 10'd2) >> 2);
          o_q[2] <= 8'((blk_i.sum_b + 10'd2) >> 2);
        end
      end
      StSqrt: begin
        rad_q <= rad_q << 2;
        if (!trial[42]) begin
          rem_q  <= trial[41:0];
          root_q <= {root_q[19:0], 1'b1};
        end else begin
          rem_q  <= {rem_q[39:0], rad_q[39:38]};
          root_q <= {root_q[19:0], 1'b0};
        end
        if (it_q == 6'd19) it_q <= '0;
        else it_q <= it_q + 6'd1;
      end
      StDiv: begin
        if (it_q == 6'd0) begin
          // load numerator 2^30 + q/2 now that the root is final
          quo_q  <= {31'(32'h4000_0000 + 32'(root_q >> 1)), 1'b0};
          dnum_q <= '0;
        end
        if (it_q != 6'd0) begin
          if (!dtry[32]) begin
            dnum_q <= dtry[31:0];
            quo_q  <= {quo_q[30:0], 1'b1};
          end else begin
            dnum_q <= dshift;
            quo_q  <= {quo_q[30:0], 1'b0};
          end
        end
        it_q <= it_q + 6'd1;
      end
      StMul: begin
        prod_q <= 44'(n_q[ch_q] * $signed({1'b0, quo_q[21:0]})) + 44'sd1048576;
      end
      StEnc: begin
        o_q[ch_q] <= enc;
        ch_q <= ch_q + 2'd1;
      end
      StOut: ;
      default: ;
    endcase
  end

endmodule

// File: hdl/mip_downsample_2x2_rgba_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_downsample_2x2_rgba_core: streaming 2x2 mip reducer for RGBA8 pixels
//
//  channel   | signals                         | direction
//  ----------+---------------------------------+----------
//  pixel in  | in_valid_i/in_ready_o + RGBA    | input
//  mip out   | out_valid_o/out_ready_i + RGBA  | output
//  config    | cfg_we_i, cfg_index_i, cfg_data_i | input
//
// The front takes one pixel per cycle unless a block waits on a full queue;
// each block sum is registered in stage 2 and pushed to the queue from there.
// Box pixels and zero normals go straight to output; other normal pixels run
// 20 sqrt steps, the divide steps, then a multiply and an encode per channel.
// Reset clears counters, sizes to 1 and the queue, but not the line memory.
// ----------------------------------------------------------------------------
module mip_downsample_2x2_rgba_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  alpha_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic [7:0]  alpha_out_o,
  output logic        last_of_image_o
);

  mds_pkg::blk_t blk_in, blk_out;
  logic push, full, pop, empty;

  mds_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .red_i(red_in_i), .green_i(green_in_i), .blue_i(blue_in_i), .alpha_i(alpha_in_i),
    .blk_full_i(full), .blk_push_o(push), .blk_o(blk_in)
  );

  mds_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(blk_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(blk_out)
  );

  mds_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .blk_i(blk_out), .pop_o(pop),
    .out_valid_o, .out_ready_i,
    .red_o(red_out_o), .green_o(green_out_o), .blue_o(blue_out_o),
    .alpha_o(alpha_out_o), .last_o(last_of_image_o)
  );

endmodule
